// ===== rtl/fsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants for the fixed-size slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

    // Request kinds on the input word.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_REUSED = 3'd0;
    localparam logic [2:0] ST_FRESH  = 3'd1;
    localparam logic [2:0] ST_FREED  = 3'd2;
    localparam logic [2:0] ST_NULL   = 3'd3;
    localparam logic [2:0] ST_OOR    = 3'd4;
    localparam logic [2:0] ST_FULL   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SLOT_SIZE     = 2'd0;
    localparam logic [1:0] CFG_REGION_BASE   = 2'd1;
    localparam logic [1:0] CFG_REGION_BLOCKS = 2'd2;

    // Field widths and fixed limits.
    localparam int SLOT_W   = 13;
    localparam int BLOCKS_W = 17;
    localparam int ADDR_W   = 32;

    localparam logic [SLOT_W-1:0] SLOT_MIN     = 13'd8;
    localparam logic [SLOT_W-1:0] SLOT_MAX     = 13'd4096;
    localparam logic [ADDR_W-1:0] HEADER_BYTES = 32'd8;

    // Input word.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
    } fsa_req_t;

    // Result word.
    typedef struct packed {
        logic [ADDR_W-1:0] slot_addr;
        logic [2:0]        status;
    } fsa_res_t;

    // Request class decided by the front end.
    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_NULL  = 2'd2
    } fsa_kind_t;

    // Classified word passed from front to back.
    typedef struct packed {
        fsa_kind_t         kind;
        logic [ADDR_W-1:0] addr;
    } fsa_cmd_t;

    // Effective configuration seen by the back end.
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   region_base;
        logic [BLOCKS_W-1:0] region_blocks;
    } fsa_cfg_t;

endpackage

// ===== rtl/fsa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_queue
// Two-entry word queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module fsa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/fsa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_front
// Accepts request words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module fsa_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  fsa_pkg::fsa_req_t req,
    output logic             cmd_empty,
    output fsa_pkg::fsa_cmd_t cmd,
    input  logic             cmd_pop
);

    fsa_pkg::fsa_cmd_t                     cls;
    logic [$bits(fsa_pkg::fsa_cmd_t)-1:0]  q_dout;

    // A free of the null address is marked so the back end drops it at once.
    always_comb
    begin
        cls.addr = req.addr;
        if (req.op == fsa_pkg::OP_FREE)
        begin
            cls.kind = (req.addr == '0) ? fsa_pkg::K_NULL : fsa_pkg::K_FREE;
        end
        else
        begin
            cls.kind = fsa_pkg::K_ALLOC;
        end
    end

    fsa_queue #(
        .WIDTH($bits(fsa_pkg::fsa_cmd_t))
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (cls),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (q_dout)
    );

    assign cmd = fsa_pkg::fsa_cmd_t'(q_dout);

endmodule

// ===== rtl/fsa_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_mod
// Bit-serial remainder unit: 32-bit dividend modulo a 13-bit divisor.
// ----------------------------------------------------------------------------
module fsa_mod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [12:0] divisor,
    output logic        done,
    output logic [12:0] rem
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [12:0] rem_reg;
    logic [13:0] trial;
    logic [12:0] rem_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        if (trial >= {1'b0, divisor})
        begin
            rem_step = 13'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_step = trial[12:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 13'd0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/fsa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_back
// Executes classified requests: free stack, bump pointer and block carving.
// ----------------------------------------------------------------------------
module fsa_back #(
    parameter int BLOCK_BYTES = 4096,
    parameter int FREE_DEPTH  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fsa_pkg::fsa_cfg_t cfg,
    input  logic              cmd_empty,
    input  fsa_pkg::fsa_cmd_t cmd,
    output logic              cmd_pop,
    input  logic              rsp_full,
    output logic              rsp_push,
    output fsa_pkg::fsa_res_t rsp
);

    localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int IDX_W  = $clog2(FREE_DEPTH);
    localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
    localparam int PROD_W = fsa_pkg::BLOCKS_W + BB_W;
    localparam int BLK_W  = ((PROD_W > 32) ? PROD_W : 32) + 2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_DEPTH);
    localparam logic [BLK_W-1:0] ADDR_TOP = BLK_W'(64'd4294967296);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_POP     = 7'b0000010,
        S_CARVE_A = 7'b0000100,
        S_CARVE_B = 7'b0001000,
        S_MOD     = 7'b0010000,
        S_CARVE_C = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic [CNT_W-1:0]               cnt_dec;
    logic [32:0]                    bump_reg;
    logic [32:0]                    bump_next;
    logic [33:0]                    limit_reg;
    logic [33:0]                    limit_next;
    logic [fsa_pkg::BLOCKS_W-1:0]   used_reg;
    logic [fsa_pkg::BLOCKS_W-1:0]   used_next;
    logic [PROD_W-1:0]              prod_reg;
    logic [PROD_W-1:0]              prod_next;
    logic [31:0]                    block_reg;
    logic [31:0]                    block_next;
    logic [31:0]                    body_reg;
    logic [31:0]                    body_next;
    fsa_pkg::fsa_res_t              res_reg;
    fsa_pkg::fsa_res_t              res_next;
    logic [31:0]                    mem [FREE_DEPTH];
    logic [31:0]                    rd_reg;
    logic                           mem_we;
    logic                           mem_re;
    logic [IDX_W-1:0]               widx;
    logic [IDX_W-1:0]               ridx;
    logic                           mod_start;
    logic                           mod_done;
    logic [12:0]                    mod_rem;
    logic                           at_limit;
    logic [BLK_W-1:0]               blk;
    logic [12:0]                    pad;
    logic [32:0]                    bump_first;

    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign widx    = cnt_reg[IDX_W-1:0];
    assign ridx    = cnt_dec[IDX_W-1:0];

    // A negative limit (slot larger than a block) is never reached.
    assign at_limit = !limit_reg[33] && (bump_reg >= limit_reg[32:0]);

    // Candidate block start and first aligned slot.
    assign blk        = BLK_W'(cfg.region_base) + BLK_W'(prod_reg);
    assign pad        = (mod_rem != 13'd0) ? (cfg.slot - mod_rem) : 13'd0;
    assign bump_first = 33'(body_reg) + 33'(pad);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bump_next  = bump_reg;
        limit_next = limit_reg;
        used_next  = used_reg;
        prod_next  = prod_reg;
        block_next = block_reg;
        body_next  = body_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mod_start  = 1'b0;
        cmd_pop    = 1'b0;
        rsp_push   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    state_next = S_DONE;
                    unique case (cmd.kind)
                        fsa_pkg::K_NULL:
                        begin
                            res_next = '{slot_addr: '0, status: fsa_pkg::ST_NULL};
                        end
                        fsa_pkg::K_FREE:
                        begin
                            if (cnt_reg == CNT_FULL)
                            begin
                                res_next = '{slot_addr: '0, status: fsa_pkg::ST_FULL};
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                                res_next = '{slot_addr: '0, status: fsa_pkg::ST_FREED};
                            end
                        end
                        fsa_pkg::K_ALLOC:
                        begin
                            if (cnt_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                cnt_next   = cnt_dec;
                                state_next = S_POP;
                            end
                            else if (at_limit)
                            begin
                                state_next = S_CARVE_A;
                            end
                            else
                            begin
                                res_next  = '{slot_addr: bump_reg[31:0],
                                              status: fsa_pkg::ST_FRESH};
                                bump_next = bump_reg + 33'(cfg.slot);
                            end
                        end
                        default:
                        begin
                            res_next = '{slot_addr: '0, status: fsa_pkg::ST_NULL};
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_next   = '{slot_addr: rd_reg, status: fsa_pkg::ST_REUSED};
                state_next = S_DONE;
            end
            S_CARVE_A:
            begin
                // Region check first, then the block offset for the next step.
                if (used_reg >= cfg.region_blocks)
                begin
                    res_next   = '{slot_addr: '0, status: fsa_pkg::ST_OOR};
                    state_next = S_DONE;
                end
                else
                begin
                    prod_next  = PROD_W'(used_reg) * PROD_W'(BLOCK_BYTES);
                    state_next = S_CARVE_B;
                end
            end
            S_CARVE_B:
            begin
                // The block must end inside the 32-bit address space.
                if ((blk + BLK_W'(BLOCK_BYTES)) > ADDR_TOP)
                begin
                    res_next   = '{slot_addr: '0, status: fsa_pkg::ST_OOR};
                    state_next = S_DONE;
                end
                else
                begin
                    block_next = blk[31:0];
                    body_next  = blk[31:0] + fsa_pkg::HEADER_BYTES;
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_CARVE_C;
                end
            end
            S_CARVE_C:
            begin
                // Align the first slot, set the new limit and hand out that slot.
                res_next   = '{slot_addr: bump_first[31:0], status: fsa_pkg::ST_FRESH};
                bump_next  = bump_first + 33'(cfg.slot);
                limit_next = 34'(block_reg) + 34'(BLOCK_BYTES) - 34'(cfg.slot) + 34'd1;
                used_next  = used_reg + fsa_pkg::BLOCKS_W'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_full)
                begin
                    rsp_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            bump_reg  <= '0;
            limit_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bump_reg  <= bump_next;
            limit_reg <= limit_next;
            used_reg  <= used_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        block_reg <= block_next;
        body_reg  <= body_next;
        res_reg   <= res_next;
    end

    // Free stack memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[widx] <= cmd.addr;
        end
        if (mem_re)
        begin
            rd_reg <= mem[ridx];
        end
    end

    fsa_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (body_next),
        .divisor  (cfg.slot),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign rsp = res_reg;

endmodule

// ===== rtl/fixed_slot_allocator.sv =====
`timescale 1ns / 1ps
// A free, a null free or a bump allocation passes the back end through S_IDLE
// and S_DONE; a reuse from the free stack adds S_POP for the registered stack
// read, and a carve of a new block adds S_CARVE_A, S_CARVE_B, S_MOD, S_CARVE_C.
// The back end takes one request at a time; a carve holds it while the
// bit-serial remainder unit runs, plus setup.
// Reset clears pointers, counters and queues and loads a slot length of 8,
// region_base 0, region_blocks 16; the free stack memory is not cleared.
// ----------------------------------------------------------------------------
// fixed_slot_allocator
// Fixed-size slot allocator with a LIFO free stack and region-backed blocks.
// ----------------------------------------------------------------------------
module fixed_slot_allocator #(
    parameter int BLOCK_BYTES = 4096,
    parameter int FREE_DEPTH  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  fsa_pkg::fsa_req_t req,
    output logic              empty,
    input  logic              pop,
    output fsa_pkg::fsa_res_t rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_idx,
    input  logic [31:0]       cfg_data
);

    logic [fsa_pkg::SLOT_W-1:0]   slot_len_reg;
    logic [31:0]                  region_base_reg;
    logic [fsa_pkg::BLOCKS_W-1:0] region_blocks_reg;
    fsa_pkg::fsa_cfg_t            cfg;
    logic                         cmd_empty;
    fsa_pkg::fsa_cmd_t            cmd;
    logic                         cmd_pop;
    logic                         rsp_full;
    logic                         rsp_push;
    fsa_pkg::fsa_res_t            res_word;
    logic [$bits(fsa_pkg::fsa_res_t)-1:0] rq_dout;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_len_reg      <= 13'd8;
            region_base_reg   <= 32'd0;
            region_blocks_reg <= 17'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                fsa_pkg::CFG_SLOT_SIZE:     slot_len_reg      <= cfg_data[12:0];
                fsa_pkg::CFG_REGION_BASE:   region_base_reg   <= cfg_data;
                fsa_pkg::CFG_REGION_BLOCKS: region_blocks_reg <= cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    // Slot size is clamped to its legal range.
    always_comb
    begin
        if (slot_len_reg < fsa_pkg::SLOT_MIN)
        begin
            cfg.slot = fsa_pkg::SLOT_MIN;
        end
        else if (slot_len_reg > fsa_pkg::SLOT_MAX)
        begin
            cfg.slot = fsa_pkg::SLOT_MAX;
        end
        else
        begin
            cfg.slot = slot_len_reg;
        end
        cfg.region_base   = region_base_reg;
        cfg.region_blocks = region_blocks_reg;
    end

    fsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    fsa_back #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .FREE_DEPTH  (FREE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_full  (rsp_full),
        .rsp_push  (rsp_push),
        .rsp       (res_word)
    );

    // Result queue decouples the back end from the consumer.
    fsa_queue #(
        .WIDTH($bits(fsa_pkg::fsa_res_t))
    ) u_rsp_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .full  (rsp_full),
        .din   (res_word),
        .pop   (pop),
        .empty (empty),
        .dout  (rq_dout)
    );

    assign rsp = fsa_pkg::fsa_res_t'(rq_dout);

endmodule
